// ----- rtl/q4k_pkg.sv -----
// Shared types, constants and conversion functions for the Q4_K dot product block.
// No dependencies; every other RTL file imports it.
`default_nettype none
package q4k_pkg;

   localparam int LANES_DEF        = 8;
   localparam int GROUP_SIZE       = 32;
   localparam int GROUPS_PER_SUPER = 8;
   localparam int PAIRS_PER_SUPER  = GROUPS_PER_SUPER / 2;
   localparam int PROD_W           = 12;   // nibble times int8 activation
   localparam int GSUM_W           = 18;   // exact group sum of 32 products

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_PAIR   = 2'd1;
   localparam logic [1:0] CMD_DATA   = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   localparam logic [1:0] FOP_ADD = 2'd0;
   localparam logic [1:0] FOP_SUB = 2'd1;
   localparam logic [1:0] FOP_MUL = 2'd2;

   // destinations of a float step result
   localparam logic [2:0] DST_T      = 3'd0;
   localparam logic [2:0] DST_U      = 3'd1;
   localparam logic [2:0] DST_MIN    = 3'd2;
   localparam logic [2:0] DST_SCALED = 3'd3;
   localparam logic [2:0] DST_TOTAL  = 3'd4;

   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   // exact half to single conversion, subnormals normalized
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] r;
      logic [9:0]  mn;
      int          p;
      p  = 0;
      mn = h[9:0];
      if (h[14:10] == 5'd0) begin
         if (h[9:0] == 10'd0) begin
            r = {h[15], 31'd0};
         end else begin
            for (int k = 0; k < 10; k++) begin
               if (h[k]) p = k;
            end
            mn = h[9:0] << (10 - p);
            r  = {h[15], 8'(103 + p), mn, 13'd0};
         end
      end else if (h[14:10] == 5'h1F) begin
         r = {h[15], 8'hFF, h[9:0], 13'd0};
      end else begin
         r = {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
      end
      return r;
   endfunction

   // exact signed integer to single conversion
   function automatic logic [31:0] int_to_single(input logic signed [GSUM_W-1:0] x);
      logic [GSUM_W-1:0] mag;
      logic [GSUM_W-1:0] sh;
      logic [31:0]       r;
      int                p;
      p   = 0;
      mag = x[GSUM_W-1] ? GSUM_W'(-x) : GSUM_W'(x);
      for (int k = 0; k < GSUM_W; k++) begin
         if (mag[k]) p = k;
      end
      sh = mag << (GSUM_W - 1 - p);
      if (mag == '0) begin
         r = 32'd0;
      end else begin
         r = {x[GSUM_W-1], 8'(127 + p), sh[GSUM_W-2:0], {(24 - GSUM_W){1'b0}}};
      end
      return r;
   endfunction

   function automatic logic [31:0] six_to_single(input logic [5:0] v);
      return int_to_single(GSUM_W'(signed'({1'b0, v})));
   endfunction

   function automatic logic [7:0] store_byte(input logic [95:0] st, input int j);
      return st[8*j +: 8];
   endfunction

   // 6-bit group scale from the packed scale bytes
   function automatic logic [5:0] group_scale(input logic [95:0] st, input logic [2:0] g);
      int gi;
      logic [7:0] b0, b1;
      gi = int'(g);
      b0 = store_byte(st, gi % 4);
      b1 = store_byte(st, gi + 4);
      if (gi < 4) return b0[5:0];
      return {b0[7:6], b1[3:0]};
   endfunction

   // 6-bit group minimum from the packed scale bytes
   function automatic logic [5:0] group_min(input logic [95:0] st, input logic [2:0] g);
      int gi;
      logic [7:0] bg, b4;
      gi = int'(g);
      bg = store_byte(st, gi);
      b4 = store_byte(st, gi + 4);
      if (gi < 4) return b4[5:0];
      return {bg[7:6], b4[7:4]};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/q4k_lane.sv -----
// One multiply lane: weight nibbles times signed int8 activations, registered.
// Depends on q4k_pkg.
`default_nettype none
module q4k_lane (
   input  wire logic                              clock,
   input  wire logic                              load,
   input  wire logic [7:0]                        weight_byte,
   input  wire logic [7:0]                        act_even,
   input  wire logic [7:0]                        act_odd,
   output logic signed [q4k_pkg::PROD_W-1:0]      prod_even,
   output logic signed [q4k_pkg::PROD_W-1:0]      prod_odd
);
   import q4k_pkg::*;

   logic signed [PROD_W-1:0] full_even, full_odd;
   logic signed [PROD_W-1:0] prod_even_ff, prod_even_in;
   logic signed [PROD_W-1:0] prod_odd_ff, prod_odd_in;

   // low nibble feeds the even block, high nibble the odd block
   always_comb begin
      full_even    = $signed({1'b0, weight_byte[3:0]}) * $signed(act_even);
      full_odd     = $signed({1'b0, weight_byte[7:4]}) * $signed(act_odd);
      prod_even_in = load ? full_even : prod_even_ff;
      prod_odd_in  = load ? full_odd : prod_odd_ff;
   end

   always_ff @(posedge clock) begin
      prod_even_ff <= prod_even_in;
      prod_odd_ff  <= prod_odd_in;
   end

   assign prod_even = prod_even_ff;
   assign prod_odd  = prod_odd_ff;

endmodule
`default_nettype wire

// ----- rtl/q4k_fpu.sv -----
// Shared single-precision add/subtract/multiply unit, three stages, round to nearest even.
// Depends on q4k_pkg.
`default_nettype none
module q4k_fpu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire q4k_pkg::fpu_req_type  req,
   output logic                       done,
   output logic [31:0]                result
);
   import q4k_pkg::*;

   // stage 1: unpack, multiply or align and add
   logic               v1_ff, v1_in;
   logic               s1_sign_ff, s1_sign_in;
   logic signed [10:0] s1_exp_ff, s1_exp_in;
   logic [47:0]        s1_man_ff, s1_man_in;
   logic               s1_spec_ff, s1_spec_in;
   logic [31:0]        s1_sval_ff, s1_sval_in;
   // stage 2: normalized mantissa with sticky
   logic               v2_ff, v2_in;
   logic               s2_sign_ff, s2_sign_in;
   logic signed [10:0] s2_exp_ff, s2_exp_in;
   logic [26:0]        s2_man_ff, s2_man_in;
   logic               s2_spec_ff, s2_spec_in;
   logic [31:0]        s2_sval_ff, s2_sval_in;
   // stage 3: rounded result
   logic               v3_ff, v3_in;
   logic [31:0]        res_ff, res_in;

   logic [31:0]        ax, bx, xv, yv;
   logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
   logic [23:0]        ma, mb, xm, ym;
   logic signed [10:0] ea, eb, xe, ye, diff;
   logic [47:0]        prod;
   logic [5:0]         shamt, lz;
   logic [53:0]        tmp;
   logic [26:0]        yal;
   logic [27:0]        sum28;
   logic [47:0]        pn;
   int                 top;

   function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                              input logic [26:0] m);
      logic [26:0]        mm;
      logic [53:0]        t;
      logic [24:0]        rs;
      logic               up;
      logic signed [10:0] ef;
      logic [31:0]        r;
      int                 sh;
      mm = m;
      sh = 0;
      if (e <= 11'sd0) begin
         sh = 1 - int'(e);
         if (sh > 27) sh = 27;
         t  = {m, 27'd0} >> sh;
         mm = {t[53:28], t[27] | (|t[26:0])};
      end
      up = mm[2] & (mm[1] | mm[0] | mm[3]);
      rs = {1'b0, mm[26:3]} + 25'(up);
      ef = e + 11'(rs[24]);
      if (m == 27'd0) begin
         r = {s, 31'd0};
      end else if (e <= 11'sd0) begin
         r = {s, 7'd0, rs[23], rs[22:0]};
      end else if (ef >= 11'sd255) begin
         r = {s, 8'hFF, 23'd0};
      end else begin
         r = {s, ef[7:0], rs[24] ? rs[23:1] : rs[22:0]};
      end
      return r;
   endfunction

   // stage 1 datapath
   always_comb begin
      ax     = req.a;
      bx     = (req.op == FOP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
      nan_a  = (&ax[30:23]) && (|ax[22:0]);
      nan_b  = (&bx[30:23]) && (|bx[22:0]);
      inf_a  = (&ax[30:23]) && !(|ax[22:0]);
      inf_b  = (&bx[30:23]) && !(|bx[22:0]);
      zero_a = !(|ax[30:0]);
      zero_b = !(|bx[30:0]);
      ma     = {|ax[30:23], ax[22:0]};
      mb     = {|bx[30:23], bx[22:0]};
      ea     = (|ax[30:23]) ? {3'd0, ax[30:23]} : 11'sd1;
      eb     = (|bx[30:23]) ? {3'd0, bx[30:23]} : 11'sd1;
      prod   = ma * mb;
      // larger magnitude goes first for the add path
      swap   = bx[30:0] > ax[30:0];
      xv     = swap ? bx : ax;
      yv     = swap ? ax : bx;
      xm     = swap ? mb : ma;
      ym     = swap ? ma : mb;
      xe     = swap ? eb : ea;
      ye     = swap ? ea : eb;
      diff   = xe - ye;
      shamt  = (diff > 11'sd27) ? 6'd27 : diff[5:0];
      tmp    = {ym, 3'd0, 27'd0} >> shamt;
      yal    = {tmp[53:28], tmp[27] | (|tmp[26:0])};
      sum28  = (xv[31] == yv[31]) ? ({1'b0, xm, 3'd0} + {1'b0, yal})
                                  : ({1'b0, xm, 3'd0} - {1'b0, yal});
      v1_in  = req.start;
      if (req.op == FOP_MUL) begin
         s1_sign_in = ax[31] ^ bx[31];
         s1_exp_in  = ea + eb - 11'sd126;
         s1_man_in  = prod;
         s1_spec_in = nan_a || nan_b || inf_a || inf_b;
         s1_sval_in = (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
                      ? QNAN : {ax[31] ^ bx[31], 8'hFF, 23'd0};
      end else begin
         s1_sign_in = (sum28 == 28'd0) ? (xv[31] & yv[31]) : xv[31];
         s1_exp_in  = xe + 11'sd1;
         s1_man_in  = {sum28, 20'd0};
         s1_spec_in = nan_a || nan_b || inf_a || inf_b;
         s1_sval_in = (nan_a || nan_b || (inf_a && inf_b && (ax[31] != bx[31])))
                      ? QNAN : (inf_a ? ax : bx);
      end
   end

   // stage 2: find the leading one and normalize
   always_comb begin
      top = 0;
      for (int k = 0; k < 48; k++) begin
         if (s1_man_ff[k]) top = k;
      end
      lz         = 6'(47 - top);
      pn         = s1_man_ff << lz;
      v2_in      = v1_ff;
      s2_sign_in = s1_sign_ff;
      s2_exp_in  = s1_exp_ff - 11'(lz);
      s2_man_in  = (s1_man_ff == 48'd0) ? 27'd0 : {pn[47:22], |pn[21:0]};
      s2_spec_in = s1_spec_ff;
      s2_sval_in = s1_sval_ff;
   end

   // stage 3: round and pack
   always_comb begin
      v3_in  = v2_ff;
      res_in = s2_spec_ff ? s2_sval_ff : round_pack(s2_sign_ff, s2_exp_ff, s2_man_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      s1_sign_ff <= s1_sign_in;
      s1_exp_ff  <= s1_exp_in;
      s1_man_ff  <= s1_man_in;
      s1_spec_ff <= s1_spec_in;
      s1_sval_ff <= s1_sval_in;
      s2_sign_ff <= s2_sign_in;
      s2_exp_ff  <= s2_exp_in;
      s2_man_ff  <= s2_man_in;
      s2_spec_ff <= s2_spec_in;
      s2_sval_ff <= s2_sval_in;
      res_ff     <= res_in;
   end

   assign done   = v3_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ----- rtl/q4k_dot_seq.sv -----
// Fold sequencer step decode: picks operation, operands and destination for each step.
// Depends on q4k_pkg.
`default_nettype none
module q4k_dot_seq (
   input  wire logic [3:0]                        step,
   input  wire logic [1:0]                        pair,
   input  wire logic [95:0]                       scale_store,
   input  wire logic [15:0]                       wscale,
   input  wire logic [15:0]                       wmin,
   input  wire logic [15:0]                       yd_even,
   input  wire logic [15:0]                       s_even,
   input  wire logic [15:0]                       yd_odd,
   input  wire logic [15:0]                       s_odd,
   input  wire logic signed [q4k_pkg::GSUM_W-1:0] sum_even,
   input  wire logic signed [q4k_pkg::GSUM_W-1:0] sum_odd,
   input  wire logic [31:0]                       min_acc,
   input  wire logic [31:0]                       scaled_acc,
   input  wire logic [31:0]                       total_acc,
   input  wire logic [31:0]                       t_val,
   input  wire logic [31:0]                       u_val,
   output logic [1:0]                             op,
   output logic [31:0]                            opa,
   output logic [31:0]                            opb,
   output logic [2:0]                             dest
);
   import q4k_pkg::*;

   logic                     odd;
   logic [3:0]               k;
   logic [2:0]               g;
   logic [15:0]              yd, sv;
   logic signed [GSUM_W-1:0] gs;

   // group steps repeat for the odd group at an offset of five
   always_comb begin
      odd  = (step >= 4'd5) && (step <= 4'd9);
      k    = odd ? step - 4'd5 : step;
      g    = {pair, odd};
      yd   = odd ? yd_odd : yd_even;
      sv   = odd ? s_odd : s_even;
      gs   = odd ? sum_odd : sum_even;
      op   = FOP_MUL;
      opa  = t_val;
      opb  = u_val;
      dest = DST_T;
      case (k)
         4'd0: begin
            opa = half_to_single(sv);
            opb = six_to_single(group_min(scale_store, g));
         end
         4'd1: begin
            op   = FOP_ADD;
            opa  = min_acc;
            opb  = t_val;
            dest = DST_MIN;
         end
         4'd2: begin
            opa = six_to_single(group_scale(scale_store, g));
            opb = half_to_single(yd);
         end
         4'd3: begin
            opb = int_to_single(gs);
         end
         4'd4: begin
            op   = FOP_ADD;
            opa  = scaled_acc;
            opb  = t_val;
            dest = DST_SCALED;
         end
         4'd10: begin
            opa = half_to_single(wscale);
            opb = scaled_acc;
         end
         4'd11: begin
            opa  = half_to_single(wmin);
            opb  = min_acc;
            dest = DST_U;
         end
         4'd12: begin
            op = FOP_SUB;
         end
         4'd13: begin
            op   = FOP_ADD;
            opa  = total_acc;
            opb  = t_val;
            dest = DST_TOTAL;
         end
         default: begin
            op = FOP_MUL;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/q4_k_quantized_dot_product_top.sv -----
// Top level of the Q4_K x Q8_1 dot product: lanes, lane merge, fold sequencer, output beat.
// Depends on q4k_pkg, q4k_lane, q4k_fpu and q4k_dot_seq.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_cmd and header/chunk fields
//  rsp      out  rsp_valid/rsp_ready    rsp_dot_result
//
// Header, pair header and finish beats are taken in the idle state; a data chunk goes
// through lane multiply, then lane merge into the group sums.
// The last chunk of a pair adds ten float steps on the shared float unit; the last pair of a
// super-block adds the weight scale and minimum products, their difference and the total.
// Reset is synchronous and clears accumulators, counters and handshake state.
// Every input beat waits while an earlier result is still held and not taken.
`default_nettype none
module q4_k_quantized_dot_product_top #(
   parameter int LANES = q4k_pkg::LANES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_weight_scale_half,
   input  wire logic [15:0] req_weight_min_half,
   input  wire logic [63:0] req_scale_bytes_low,
   input  wire logic [31:0] req_scale_bytes_high,
   input  wire logic [15:0] req_act_scale_even,
   input  wire logic [15:0] req_act_sum_even,
   input  wire logic [15:0] req_act_scale_odd,
   input  wire logic [15:0] req_act_sum_odd,
   input  wire logic [63:0] req_weight_bytes,
   input  wire logic [63:0] req_act_bytes_even,
   input  wire logic [63:0] req_act_bytes_odd,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_dot_result
);
   import q4k_pkg::*;

   localparam int CHUNKS = (GROUP_SIZE + LANES - 1) / LANES;
   localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHUNK = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   localparam logic [3:0] STEP_FIRST     = 4'd0;
   localparam logic [3:0] STEP_PAIR_LAST = 4'd9;
   localparam logic [3:0] STEP_SUPER     = 4'd10;
   localparam logic [3:0] STEP_LAST      = 4'd13;

   logic [1:0]               state_ff, state_in;
   logic [3:0]               step_ff, step_in;
   logic [CNT_W-1:0]         chunk_ff, chunk_in;
   logic [1:0]               pair_ff, pair_in;
   logic [31:0]              total_ff, total_in;
   logic [31:0]              scaled_ff, scaled_in;
   logic [31:0]              min_ff, min_in;
   logic [31:0]              t_ff, t_in;
   logic [31:0]              u_ff, u_in;
   logic signed [GSUM_W-1:0] even_sum_ff, even_sum_in;
   logic signed [GSUM_W-1:0] odd_sum_ff, odd_sum_in;
   logic [15:0]              wscale_ff, wscale_in;
   logic [15:0]              wmin_ff, wmin_in;
   logic [95:0]              sstore_ff, sstore_in;
   logic [15:0]              yd_e_ff, yd_e_in, s_e_ff, s_e_in;
   logic [15:0]              yd_o_ff, yd_o_in, s_o_ff, s_o_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_dot_ff, rsp_dot_in;

   logic                     accept, lane_load;
   logic signed [PROD_W-1:0] prod_e [LANES];
   logic signed [PROD_W-1:0] prod_o [LANES];
   logic signed [GSUM_W-1:0] lane_sum_e, lane_sum_o;
   fpu_req_type              fpu_req;
   logic                     fpu_done;
   logic [31:0]              fpu_result;
   logic [1:0]               seq_op;
   logic [31:0]              seq_a, seq_b;
   logic [2:0]               seq_dest;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign lane_load = accept && (req_cmd == CMD_DATA);

   // lanes; lane i reads byte i mod 8
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int B = i % 8;
      q4k_lane u_lane (
         .clock       (clock),
         .load        (lane_load),
         .weight_byte (req_weight_bytes[8*B +: 8]),
         .act_even    (req_act_bytes_even[8*B +: 8]),
         .act_odd     (req_act_bytes_odd[8*B +: 8]),
         .prod_even   (prod_e[i]),
         .prod_odd    (prod_o[i])
      );
   end

   // merge the lane products
   always_comb begin
      lane_sum_e = '0;
      lane_sum_o = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_sum_e = lane_sum_e + GSUM_W'(prod_e[i]);
         lane_sum_o = lane_sum_o + GSUM_W'(prod_o[i]);
      end
   end

   q4k_dot_seq u_seq (
      .step        (step_ff),
      .pair        (pair_ff),
      .scale_store (sstore_ff),
      .wscale      (wscale_ff),
      .wmin        (wmin_ff),
      .yd_even     (yd_e_ff),
      .s_even      (s_e_ff),
      .yd_odd      (yd_o_ff),
      .s_odd       (s_o_ff),
      .sum_even    (even_sum_ff),
      .sum_odd     (odd_sum_ff),
      .min_acc     (min_ff),
      .scaled_acc  (scaled_ff),
      .total_acc   (total_ff),
      .t_val       (t_ff),
      .u_val       (u_ff),
      .op          (seq_op),
      .opa         (seq_a),
      .opb         (seq_b),
      .dest        (seq_dest)
   );

   assign fpu_req = '{start: (state_ff == ST_ISSUE), op: seq_op, a: seq_a, b: seq_b};

   q4k_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .done   (fpu_done),
      .result (fpu_result)
   );

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      chunk_in    = chunk_ff;
      pair_in     = pair_ff;
      total_in    = total_ff;
      scaled_in   = scaled_ff;
      min_in      = min_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      even_sum_in = even_sum_ff;
      odd_sum_in  = odd_sum_ff;
      wscale_in   = wscale_ff;
      wmin_in     = wmin_ff;
      sstore_in   = sstore_ff;
      yd_e_in     = yd_e_ff;
      s_e_in      = s_e_ff;
      yd_o_in     = yd_o_ff;
      s_o_in      = s_o_ff;
      rsp_dot_in  = rsp_dot_ff;
      // drop the held result once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_HEADER: begin
                     wscale_in   = req_weight_scale_half;
                     wmin_in     = req_weight_min_half;
                     sstore_in   = {req_scale_bytes_high, req_scale_bytes_low};
                     scaled_in   = 32'd0;
                     min_in      = 32'd0;
                     even_sum_in = '0;
                     odd_sum_in  = '0;
                     chunk_in    = '0;
                     pair_in     = 2'd0;
                  end
                  CMD_PAIR: begin
                     yd_e_in     = req_act_scale_even;
                     s_e_in      = req_act_sum_even;
                     yd_o_in     = req_act_scale_odd;
                     s_o_in      = req_act_sum_odd;
                     even_sum_in = '0;
                     odd_sum_in  = '0;
                     chunk_in    = '0;
                  end
                  CMD_DATA: begin
                     state_in = ST_CHUNK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_dot_in   = ((&total_ff[30:23]) && (|total_ff[22:0])) ? QNAN : total_ff;
                     total_in     = 32'd0;
                  end
               endcase
            end
         end
         ST_CHUNK: begin
            even_sum_in = even_sum_ff + lane_sum_e;
            odd_sum_in  = odd_sum_ff + lane_sum_o;
            if (chunk_ff == CNT_W'(CHUNKS - 1)) begin
               chunk_in = '0;
               step_in  = STEP_FIRST;
               state_in = ST_ISSUE;
            end else begin
               chunk_in = chunk_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         default: begin
            if (fpu_done) begin
               case (seq_dest)
                  DST_T:      t_in      = fpu_result;
                  DST_U:      u_in      = fpu_result;
                  DST_MIN:    min_in    = fpu_result;
                  DST_SCALED: scaled_in = fpu_result;
                  default:    total_in  = fpu_result;
               endcase
               state_in = ST_ISSUE;
               step_in  = step_ff + 4'd1;
               if (step_ff == STEP_PAIR_LAST) begin
                  even_sum_in = '0;
                  odd_sum_in  = '0;
                  if (pair_ff == 2'(PAIRS_PER_SUPER - 1)) begin
                     step_in = STEP_SUPER;
                  end else begin
                     pair_in  = pair_ff + 2'd1;
                     state_in = ST_IDLE;
                  end
               end else if (step_ff == STEP_LAST) begin
                  scaled_in = 32'd0;
                  min_in    = 32'd0;
                  pair_in   = 2'd0;
                  state_in  = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FIRST;
         chunk_ff     <= '0;
         pair_ff      <= 2'd0;
         total_ff     <= 32'd0;
         scaled_ff    <= 32'd0;
         min_ff       <= 32'd0;
         even_sum_ff  <= '0;
         odd_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         chunk_ff     <= chunk_in;
         pair_ff      <= pair_in;
         total_ff     <= total_in;
         scaled_ff    <= scaled_in;
         min_ff       <= min_in;
         even_sum_ff  <= even_sum_in;
         odd_sum_ff   <= odd_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff       <= t_in;
      u_ff       <= u_in;
      wscale_ff  <= wscale_in;
      wmin_ff    <= wmin_in;
      sstore_ff  <= sstore_in;
      yd_e_ff    <= yd_e_in;
      s_e_ff     <= s_e_in;
      yd_o_ff    <= yd_o_in;
      s_o_ff     <= s_o_in;
      rsp_dot_ff <= rsp_dot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dot_result = rsp_dot_ff;

   // a new result beat only follows an accepted finish
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(accept && (req_cmd == CMD_FINISH)))
      else $error("result beat without finish");

   // no input beat while a chunk or fold is in flight
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input accepted while busy");

   // float results arrive only while the sequencer waits for them
   a_fpu_done_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> (state_ff == ST_WAIT))
      else $error("float result outside wait");

endmodule
`default_nettype wire

// ----- dv/tb_q4_k_quantized_dot_product_top.sv -----
// Self-checking testbench for q4_k_quantized_dot_product_top: directed and random
// super-block streams checked against a bit-exact single-precision dot product predictor.
// Depends on q4k_pkg and the RTL of the block; needs nothing else.
`default_nettype none
module tb_q4_k_quantized_dot_product_top;
   timeunit 1ns;
   timeprecision 1ps;
   import q4k_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_OFF_CYCLES = 700;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct {
      logic [1:0]  cmd;
      logic [15:0] wscale, wmin;
      logic [63:0] sb_low;
      logic [31:0] sb_high;
      logic [15:0] yd_even, s_even, yd_odd, s_odd;
      logic [63:0] wbytes, abytes_even, abytes_odd;
   } beat_type;

   // Dot product predictor: single precision emulated on doubles, rounded per step
   class dot_scoreboard;
      logic [31:0] total, scaled_sum, min_sum;
      logic [15:0] wscale, wmin;
      logic [95:0] scale_bytes;
      logic [15:0] yd_even, s_even, yd_odd, s_odd;
      int          even_sum, odd_sum, chunks, pairs;
      logic [31:0] dot_q[$];

      function void clear();
         total = 0; scaled_sum = 0; min_sum = 0;
         even_sum = 0; odd_sum = 0; chunks = 0; pairs = 0;
         dot_q.delete();
      endfunction

      static function real f2r(logic [31:0] f);
         real v;
         if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
         if (f[30:23] == 8'h00) begin
            if (f[22:0] == 0) return $bitstoreal({f[31], 63'd0});
            v = f[22:0] * 2.0 ** (-149);
            return f[31] ? -v : v;
         end
         return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
      endfunction

      // round a double to the nearest single, ties to even
      static function logic [31:0] r2f(real x);
         logic [63:0] d, sig, q, rem, half;
         logic        s;
         int          e, sh;
         d = $realtobits(x);
         s = d[63];
         if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'd0};
         if (d[62:52] == 11'h000) return {s, 31'd0};
         e = int'(d[62:52]) - 1023;
         sig = {11'd0, 1'b1, d[51:0]};
         sh = (e >= -126) ? 29 : 29 + (-126 - e);
         if (sh > 60) return {s, 31'd0};
         q = sig >> sh;
         rem = sig & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 1;
         if (e >= -126) begin
            if (q[24]) begin
               q = q >> 1;
               e = e + 1;
            end
            if (e > 127) return {s, 8'hFF, 23'd0};
            return {s, 8'(e + 127), q[22:0]};
         end
         return {s, q[30:0]};
      endfunction

      static function logic [31:0] h2f(logic [15:0] h);
         if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
         if (h[14:10] == 5'h00) begin
            if (h[9:0] == 0) return {h[15], 31'd0};
            return r2f((h[15] ? -1.0 : 1.0) * h[9:0] * 2.0 ** (-24));
         end
         return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
      endfunction

      static function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
         return r2f(f2r(a) * f2r(b));
      endfunction

      static function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
         return r2f(f2r(a) + f2r(b));
      endfunction

      function logic [7:0] sbyte(int j);
         return scale_bytes[8*j +: 8];
      endfunction

      // fold one finished group into the scaled and minimum sums
      function void fold_group(int g, int gsum, logic [15:0] yd, logic [15:0] sterm);
         int sc, mn;
         logic [31:0] t;
         if (g < 4) begin
            sc = sbyte(g) & 63;
            mn = sbyte(g + 4) & 63;
         end else begin
            sc = (sbyte(g + 4) & 15) | ((sbyte(g - 4) >> 6) << 4);
            mn = (sbyte(g + 4) >> 4) | ((sbyte(g) >> 6) << 4);
         end
         t = r2f(f2r(h2f(sterm)) * real'(mn));
         min_sum = fadd(min_sum, t);
         t = r2f(real'(sc) * f2r(h2f(yd)));
         t = r2f(f2r(t) * real'(gsum));
         scaled_sum = fadd(scaled_sum, t);
      endfunction

      function void note_beat(beat_type b);
         logic [31:0] x, y;
         logic [7:0] w;
         case (b.cmd)
            CMD_HEADER: begin
               wscale = b.wscale; wmin = b.wmin;
               scale_bytes = {b.sb_high, b.sb_low};
               scaled_sum = 0; min_sum = 0;
               even_sum = 0; odd_sum = 0; chunks = 0; pairs = 0;
            end
            CMD_PAIR: begin
               yd_even = b.yd_even; s_even = b.s_even;
               yd_odd = b.yd_odd; s_odd = b.s_odd;
               even_sum = 0; odd_sum = 0; chunks = 0;
            end
            CMD_DATA: begin
               for (int i = 0; i < 8; i++) begin
                  w = b.wbytes[8*i +: 8];
                  even_sum += int'(w[3:0]) * int'($signed(b.abytes_even[8*i +: 8]));
                  odd_sum += int'(w[7:4]) * int'($signed(b.abytes_odd[8*i +: 8]));
               end
               chunks++;
               if (chunks >= GROUP_SIZE / 8) begin
                  fold_group(2 * pairs, even_sum, yd_even, s_even);
                  fold_group(2 * pairs + 1, odd_sum, yd_odd, s_odd);
                  even_sum = 0; odd_sum = 0; chunks = 0;
                  pairs++;
                  if (pairs >= PAIRS_PER_SUPER) begin
                     x = fmul(h2f(wscale), scaled_sum);
                     y = fmul(h2f(wmin), min_sum);
                     total = fadd(total, r2f(f2r(x) - f2r(y)));
                     scaled_sum = 0; min_sum = 0; pairs = 0;
                  end
               end
            end
            default: begin
               x = total;
               if (x[30:23] == 8'hFF && x[22:0] != 0) x = QNAN;
               dot_q.push_back(x);
               total = 0;
            end
         endcase
      endfunction

      // pop the oldest expected total; returns 0 if none is waiting
      function bit check_dot(logic [31:0] got, output logic [31:0] want);
         want = 'x;
         if (dot_q.size() == 0) return 0;
         want = dot_q.pop_front();
         return 1;
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_cmd;
   logic [15:0] req_weight_scale_half, req_weight_min_half;
   logic [63:0] req_scale_bytes_low;
   logic [31:0] req_scale_bytes_high;
   logic [15:0] req_act_scale_even, req_act_sum_even, req_act_scale_odd, req_act_sum_odd;
   logic [63:0] req_weight_bytes, req_act_bytes_even, req_act_bytes_odd;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_dot_result;

   q4_k_quantized_dot_product_top dut (.*);

   dot_scoreboard sb;
   beat_type      beat_q[$];
   int            mismatches = 0;
   int            beats_sent = 0;
   int            dots_seen = 0;
   int            phase = 0;
   int            idle_cycles = 0;

   initial begin
      clock = 0;
      forever begin
         #10 clock = 1;
         #10 clock = 0;
      end
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR @%0t: %s got %08h expected %08h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic [15:0] rand_half();
      if ($urandom_range(7) == 0) return 16'($urandom);
      return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
   endfunction

   function automatic beat_type rand_beat(logic [1:0] cmd);
      beat_type b;
      b.cmd = cmd;
      b.wscale = rand_half(); b.wmin = rand_half();
      b.sb_low = {$urandom, $urandom}; b.sb_high = $urandom;
      b.yd_even = rand_half(); b.s_even = rand_half();
      b.yd_odd = rand_half(); b.s_odd = rand_half();
      b.wbytes = {$urandom, $urandom};
      b.abytes_even = {$urandom, $urandom};
      b.abytes_odd = {$urandom, $urandom};
      return b;
   endfunction

   task automatic push_pair(int nchunks);
      beat_q.push_back(rand_beat(CMD_PAIR));
      repeat (nchunks) beat_q.push_back(rand_beat(CMD_DATA));
   endtask

   // random super-blocks, mostly well formed, some noise and broken ones
   task automatic gen_random(int n);
      int target, r;
      target = beat_q.size() + n;
      while (beat_q.size() < target) begin
         r = $urandom_range(15);
         if (r == 0) begin
            beat_q.push_back(rand_beat(2'($urandom)));
         end else if (r == 1) begin
            beat_q.push_back(rand_beat(CMD_HEADER));
            repeat ($urandom_range(3)) push_pair($urandom_range(5));
         end else begin
            beat_q.push_back(rand_beat(CMD_HEADER));
            for (int p = 0; p < PAIRS_PER_SUPER; p++) begin
               if ($urandom_range(15) == 0) beat_q.push_back(rand_beat(CMD_FINISH));
               push_pair(GROUP_SIZE / 8);
            end
         end
         if ($urandom_range(1)) beat_q.push_back(rand_beat(CMD_FINISH));
      end
   endtask

   task automatic gen_directed();
      beat_type b;
      beat_q.push_back(rand_beat(CMD_FINISH));
      // extreme super-block: all-ones scale bytes, full-scale weights (zero on pair 1) and activations
      b = rand_beat(CMD_HEADER);
      b.wscale = 16'h3C00; b.wmin = 16'h0001;
      b.sb_low = '1; b.sb_high = '1;
      beat_q.push_back(b);
      for (int p = 0; p < PAIRS_PER_SUPER; p++) begin
         b = rand_beat(CMD_PAIR);
         b.yd_even = (p == 0) ? 16'h7BFF : 16'h03FF;
         b.s_even = (p == 1) ? 16'h8000 : 16'h0001;
         b.yd_odd = (p == 3) ? 16'hFE01 : 16'h3C00;
         b.s_odd = (p == 2) ? 16'h7C00 : 16'hBC00;
         beat_q.push_back(b);
         for (int c = 0; c < GROUP_SIZE / 8; c++) begin
            b = rand_beat(CMD_DATA);
            b.wbytes = (p == 1) ? 64'd0 : '1;
            b.abytes_even = {8{8'h80}};
            b.abytes_odd = {8{8'h7F}};
            beat_q.push_back(b);
         end
      end
      beat_q.push_back(rand_beat(CMD_FINISH));
      // restarts: header and pair header mid-way, finish inside a super-block
      beat_q.push_back(rand_beat(CMD_HEADER));
      push_pair(2);
      beat_q.push_back(rand_beat(CMD_HEADER));
      push_pair(1);
      push_pair(4);
      beat_q.push_back(rand_beat(CMD_FINISH));
      push_pair(4);
   endtask

   // drive queued beats; hold valid until accepted
   task automatic drive_beats(int idle_pct);
      beat_type b;
      while (beat_q.size() > 0) begin
         if ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            b = beat_q.pop_front();
            req_valid <= 1'b1;
            req_cmd <= b.cmd;
            req_weight_scale_half <= b.wscale; req_weight_min_half <= b.wmin;
            req_scale_bytes_low <= b.sb_low; req_scale_bytes_high <= b.sb_high;
            req_act_scale_even <= b.yd_even; req_act_sum_even <= b.s_even;
            req_act_scale_odd <= b.yd_odd; req_act_sum_odd <= b.s_odd;
            req_weight_bytes <= b.wbytes;
            req_act_bytes_even <= b.abytes_even; req_act_bytes_odd <= b.abytes_odd;
            do @(posedge clock); while (!req_ready);
            sb.note_beat(b);
            beats_sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   // stimulus and end of run
   initial begin
      sb = new();
      sb.clear();
      {req_valid, req_cmd, req_weight_scale_half, req_weight_min_half} = '0;
      {req_scale_bytes_low, req_scale_bytes_high} = '0;
      {req_act_scale_even, req_act_sum_even, req_act_scale_odd, req_act_sum_odd} = '0;
      {req_weight_bytes, req_act_bytes_even, req_act_bytes_odd} = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gen_directed();
      drive_beats(15);
      gen_random(RANDOM_ITEMS / 3);
      drive_beats(15);
      phase = 1;
      gen_random(RANDOM_ITEMS / 3);
      drive_beats(79);
      phase = 2;
      gen_random(RANDOM_ITEMS / 3);
      drive_beats(0);
      while (sb.dot_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.dot_q.size() > 0) report("leftover expected result", 'x, sb.dot_q[0]);
      $display("Covered %0d request beats and %0d dot results over three idle patterns.",
               beats_sent, dots_seen);
      if (mismatches == 0) begin
         $display("q4_k_quantized_dot_product_top: match");
      end else begin
         $display("q4_k_quantized_dot_product_top: mismatch");
      end
      $finish;
   end

   // result side: check each beat, stall per phase, one long hold-off
   initial begin
      logic [31:0] want;
      bit held;
      held = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            dots_seen++;
            if (!sb.check_dot(rsp_dot_result, want))
               report("unexpected dot result", rsp_dot_result, want);
            else if (rsp_dot_result !== want)
               report("dot_result", rsp_dot_result, want);
         end
         if (phase == 2 && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= ((phase == 0) ? 79 : (phase == 1) ? 15 : 0));
         end
      end
   end

   // watchdog on cycles with no accepted beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without progress.", idle_cycles);
            $display("q4_k_quantized_dot_product_top: mismatch");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
